FILE: design/crcb_pkg.sv
// Shared types, constants and the byte update function of the CRC-32 byte engine.
`default_nettype none

package crcb_pkg;

  // Register reset values
  localparam logic [31:0] CrcInitRst = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPolyRst = 32'hEDB8_8320;

  // Configuration register indexes (byte address bit 2)
  localparam logic RegCrcInit = 1'b0;
  localparam logic RegCrcPoly = 1'b1;

  // Input kind codes
  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindFinal = 2'd1;
  localparam logic [1:0] KindReset = 2'd2;

  // Command queue geometry (depth must be a power of two)
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Digest is sent as this many byte beats
  localparam int DigestBytes = 4;
  localparam int BurstCntW   = $clog2(DigestBytes);

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_DATA,
    OP_FINAL,
    OP_RESET,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } queue_entry_t;

  typedef struct packed {
    logic burst;
    logic locked;
  } back_status_t;

  // Fold one byte into a reflected remainder: eight shift/XOR steps
  function automatic logic [31:0] crc_byte_step(input logic [31:0] rem,
                                                input logic [7:0]  data,
                                                input logic [31:0] poly);
    logic [31:0] c;
    c = rem ^ {24'h00_0000, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/crcb_front.sv
// Front end: takes input beats, classifies the kind and pushes a command.
`default_nettype none

module crcb_front (
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            in_kind_i,
  input  wire logic [7:0]            in_data_byte_i,
  output logic                       in_stall_o,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output crcb_pkg::queue_entry_t     q_entry_o
);

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the kind; unused code becomes a no-op
  always_comb begin
    q_entry_o.data = in_data_byte_i;
    unique case (in_kind_i)
      crcb_pkg::KindData:  q_entry_o.op = crcb_pkg::OP_DATA;
      crcb_pkg::KindFinal: q_entry_o.op = crcb_pkg::OP_FINAL;
      crcb_pkg::KindReset: q_entry_o.op = crcb_pkg::OP_RESET;
      default:             q_entry_o.op = crcb_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/crcb_fifo.sv
// Short command queue between the front end and the CRC back end.
`default_nettype none

module crcb_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire crcb_pkg::queue_entry_t entry_i,
  input  wire logic                   pop_i,
  output crcb_pkg::queue_entry_t      head_o,
  output logic                        full_o,
  output logic                        empty_o
);

  crcb_pkg::queue_entry_t mem_q [crcb_pkg::QueueDepth];
  logic [crcb_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [crcb_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == crcb_pkg::QCntW'(crcb_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/crcb_back.sv
// Back end: runs commands on the remainder and drives the result register.
`default_nettype none

module crcb_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [31:0]            cfg_init_i,
  input  wire logic [31:0]            cfg_poly_i,
  input  wire crcb_pkg::queue_entry_t head_i,
  input  wire logic                   empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        out_accepted_o,
  output logic [7:0]                  out_digest_byte_o,
  output logic                        out_last_o,
  output crcb_pkg::back_status_t      status_o
);

  logic [31:0]                    rem_q, rem_d;
  logic                           locked_q, locked_d;
  logic [crcb_pkg::BurstCntW-1:0] cnt_q, cnt_d;
  logic                           valid_q, valid_d;
  logic                           acc_q, acc_d;
  logic [7:0]                     byte_q, byte_d;
  logic                           last_q, last_d;
  logic                           out_free;
  logic [31:0]                    digest;

  assign out_free = !valid_q || !out_stall_i;
  assign digest   = rem_q ^ cfg_init_i;

  // Emit pending digest beats first, else pop and run the next command
  always_comb begin
    rem_d    = rem_q;
    locked_d = locked_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    acc_d    = acc_q;
    byte_d   = byte_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (out_free) begin
      valid_d = 1'b0;
      if (cnt_q != '0) begin
        valid_d = 1'b1;
        acc_d   = 1'b1;
        byte_d  = 8'(digest >> {cnt_q - 1'b1, 3'b000});
        last_d  = (cnt_q == crcb_pkg::BurstCntW'(1));
        cnt_d   = cnt_q - 1'b1;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        acc_d   = 1'b0;
        byte_d  = 8'h00;
        last_d  = 1'b1;
        unique case (head_i.op)
          crcb_pkg::OP_DATA: begin
            if (!locked_q) begin
              rem_d = crcb_pkg::crc_byte_step(rem_q, head_i.data, cfg_poly_i);
              acc_d = 1'b1;
            end
          end
          crcb_pkg::OP_FINAL: begin
            if (!locked_q) begin
              acc_d    = 1'b1;
              byte_d   = digest[31:24];
              last_d   = 1'b0;
              cnt_d    = crcb_pkg::BurstCntW'(crcb_pkg::DigestBytes - 1);
              locked_d = 1'b1;
            end
          end
          crcb_pkg::OP_RESET: begin
            rem_d    = cfg_init_i;
            locked_d = 1'b0;
            acc_d    = 1'b1;
          end
          crcb_pkg::OP_NOP: begin
            acc_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= crcb_pkg::CrcInitRst;
      locked_q <= 1'b0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      locked_q <= locked_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o       = valid_q;
  assign out_accepted_o    = acc_q;
  assign out_digest_byte_o = byte_q;
  assign out_last_o        = last_q;
  assign status_o.burst    = (cnt_q != '0);
  assign status_o.locked   = locked_q;

endmodule

`default_nettype wire

FILE: design/crc32_byte_engine_core.sv
// Top level of the reflected byte-wise CRC-32 engine with digest lock.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   in_kind_i, in_data_byte_i
// out      output     out_valid_o / out_stall_i out_accepted_o, out_digest_byte_o, out_last_o
// cfg      input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Data, reset and rejected beats: one byte per clock while the output is not stalled.
// A finalize holds the back end until all four digest bytes are sent, one beat each.
// A four-entry command queue lets input beats keep arriving while output is stalled.
// Each result is registered in the back end as its command is popped from the queue head.
// Reset clears the lock, queue and output valid; no clearing pass is needed.
`default_nettype none

module crc32_byte_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_kind_i,
  input  wire logic [7:0]  in_data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_accepted_o,
  output logic [7:0]       out_digest_byte_o,
  output logic             out_last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0]                 init_q, poly_q;
  logic                        cfg_wr;
  logic                        q_full, q_empty, q_push, q_pop;
  crcb_pkg::queue_entry_t      q_in, q_head;
  crcb_pkg::back_status_t      status;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == crcb_pkg::RegCrcPoly) ? poly_q : init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= crcb_pkg::CrcInitRst;
      poly_q <= crcb_pkg::CrcPolyRst;
    end else if (cfg_wr) begin
      if (paddr[2] == crcb_pkg::RegCrcInit) begin
        init_q <= pwdata;
      end else begin
        poly_q <= pwdata;
      end
    end
  end

  crcb_front u_front (
    .in_valid_i     (in_valid_i),
    .in_kind_i      (in_kind_i),
    .in_data_byte_i (in_data_byte_i),
    .in_stall_o     (in_stall_o),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_in)
  );

  crcb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  crcb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_init_i        (init_q),
    .cfg_poly_i        (poly_q),
    .head_i            (q_head),
    .empty_i           (q_empty),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_accepted_o    (out_accepted_o),
    .out_digest_byte_o (out_digest_byte_o),
    .out_last_o        (out_last_o),
    .status_o          (status)
  );

  // A pending digest burst always has a beat on the output
  a_burst_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.burst |-> out_valid_o)
    else $error("digest burst pending without output beat");

  // Only accepted finalize beats are non-last
  a_nonlast_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |-> (out_accepted_o && status.locked))
    else $error("non-last beat outside an accepted finalize");

  // Rejected beats carry a zero byte
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_accepted_o) |-> (out_digest_byte_o == 8'h00))
    else $error("rejected beat carries a digest byte");

  // A taken non-last beat is followed by the next digest byte
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_last_o) |=> out_valid_o)
    else $error("digest burst broke off");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the byte-serial CRC-32 engine with digest lock.
module tb;

  // Kind code that the engine classifies as a no-op
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [2:0] AddrInit   = {crcb_pkg::RegCrcInit, 2'b00};
  localparam logic [2:0] AddrPoly   = {crcb_pkg::RegCrcPoly, 2'b00};
  localparam int LongHoldCycles     = 80;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] digest;
    logic       last;
  } crc_beat_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_kind_i      = crcb_pkg::KindData;
  logic [7:0]  in_data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        out_accepted_o;
  logic [7:0]  out_digest_byte_o;
  logic        out_last_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = 3'd0;
  logic [31:0] pwdata         = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  crc32_byte_engine_core DUT (.*);

  // Local copy of the engine state and its registers
  logic [31:0] cfg_init   = crcb_pkg::CrcInitRst;
  logic [31:0] cfg_poly   = crcb_pkg::CrcPolyRst;
  logic [31:0] crc_rem    = crcb_pkg::CrcInitRst;
  logic        crc_locked = 1'b0;

  crc_cmd_t  byte_cmd_q[$];
  crc_beat_t crc_beats_due[$];
  crc_cmd_t  next_cmd;
  crc_beat_t want_beat;

  int  err_cnt = 0;
  int  beats_checked = 0;
  int  n_data = 0, n_final = 0, n_reset = 0, n_reject = 0, n_unused = 0;
  int  n_settings = 0, n_long_holds = 0, in_stall_cycles = 0;
  bit  idle_en = 1'b1;
  bit  in_beat_done = 1'b0;
  bit  hold_request = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;

  // Clock: period 12
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Reflected table update: look up the low byte, then shift the rest in
  function automatic logic [31:0] fold_byte(input logic [31:0] rem, input logic [7:0] b,
                                            input logic [31:0] poly);
    logic [31:0] t;
    t = {24'h00_0000, rem[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ poly) : (t >> 1);
    end
    return t ^ (rem >> 8);
  endfunction

  // Advance the local state by one input beat and queue the result beats it causes
  task automatic predict_beats(input logic [1:0] kind, input logic [7:0] b);
    logic [31:0] d;
    crc_beat_t   beat;
    beat = '{accepted: 1'b0, digest: 8'h00, last: 1'b1};
    case (kind)
      crcb_pkg::KindData: begin
        if (!crc_locked) begin
          crc_rem = fold_byte(crc_rem, b, cfg_poly);
          beat.accepted = 1'b1;
          n_data++;
        end else begin
          n_reject++;
        end
      end
      crcb_pkg::KindFinal: begin
        if (!crc_locked) begin
          d = crc_rem ^ cfg_init;
          for (int i = 0; i < crcb_pkg::DigestBytes; i++) begin
            crc_beats_due.insert(crc_beats_due.size(),
                                 '{accepted: 1'b1, digest: d[31 - 8*i -: 8],
                                   last: (i == crcb_pkg::DigestBytes - 1)});
          end
          crc_locked = 1'b1;
          n_final++;
          return;
        end
        n_reject++;
      end
      crcb_pkg::KindReset: begin
        crc_rem = cfg_init;
        crc_locked = 1'b0;
        beat.accepted = 1'b1;
        n_reset++;
      end
      default: begin
        n_unused++;
      end
    endcase
    crc_beats_due.insert(crc_beats_due.size(), beat);
  endtask

  // Capture input beats taken by the engine
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_beats(in_kind_i, in_data_byte_i);
      in_beat_done = 1'b1;
    end else if (rst_ni && in_valid_i && in_stall_o) begin
      in_stall_cycles++;
    end
  end

  // Drive input beats from the pending queue, with random gaps between them
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat_done) begin
      in_beat_done = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_cmd_q.size() > 0) begin
        next_cmd = byte_cmd_q.pop_front();
        in_valid_i     <= 1'b1;
        in_kind_i      <= next_cmd.kind;
        in_data_byte_i <= next_cmd.data;
        if (idle_en && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the output side: a long hold on request, else random bursts
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LongHoldCycles;
      n_long_holds++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crc_beats_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat: expected none, got accepted %b digest %h last %b",
                 $time, out_accepted_o, out_digest_byte_o, out_last_o);
      end else begin
        want_beat = crc_beats_due.pop_front();
        check_field("accepted", {7'd0, want_beat.accepted}, {7'd0, out_accepted_o});
        check_field("digest_byte", want_beat.digest, out_digest_byte_o);
        check_field("last", {7'd0, want_beat.last}, {7'd0, out_last_o});
        beats_checked++;
      end
    end
  end

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read both registers back and compare with the local copies
  task automatic check_settings();
    logic [31:0] rd;
    apb_access(1'b0, AddrInit, 32'h0, rd);
    if (rd !== cfg_init) begin
      err_cnt++;
      $display("%0t: crc_init readback: expected %h, got %h", $time, cfg_init, rd);
    end
    apb_access(1'b0, AddrPoly, 32'h0, rd);
    if (rd !== cfg_poly) begin
      err_cnt++;
      $display("%0t: crc_poly readback: expected %h, got %h", $time, cfg_poly, rd);
    end
  endtask

  task automatic apply_settings(input logic [31:0] init, input logic [31:0] poly);
    logic [31:0] rd;
    apb_access(1'b1, AddrInit, init, rd);
    cfg_init = init;
    apb_access(1'b1, AddrPoly, poly, rd);
    cfg_poly = poly;
    check_settings();
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic queue_cmd(input logic [1:0] kind, input logic [7:0] b);
    byte_cmd_q.insert(byte_cmd_q.size(), '{kind: kind, data: b});
  endtask

  // Mostly well-formed messages (reset, bytes, finalize), some noise
  task automatic queue_random_traffic(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_cmd(crcb_pkg::KindReset, 8'($urandom_range(0, 255)));
          n++;
        end
        len = $urandom_range(0, 12);
        repeat (len) queue_cmd(crcb_pkg::KindData, 8'($urandom_range(0, 255)));
        n += len;
        queue_cmd(crcb_pkg::KindFinal, 8'($urandom_range(0, 255)));
        n++;
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        n++;
      end
    end
  endtask

  // Hold until every queued beat is sent and every result has arrived
  task automatic wait_drained();
    while (byte_cmd_q.size() != 0 || in_valid_i || crc_beats_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    string check_str;
    check_str = "123456789";
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    check_settings();
    @(posedge clk_i);

    // Directed: byte extremes, the standard check string, lock behavior, unused kind
    queue_cmd(crcb_pkg::KindData, 8'h00);
    queue_cmd(crcb_pkg::KindData, 8'hFF);
    queue_cmd(crcb_pkg::KindReset, 8'hFF);
    for (int i = 0; i < check_str.len(); i++) queue_cmd(crcb_pkg::KindData, check_str[i]);
    queue_cmd(crcb_pkg::KindFinal, 8'h00);
    queue_cmd(crcb_pkg::KindData, 8'hA5);
    queue_cmd(crcb_pkg::KindFinal, 8'hFF);
    queue_cmd(KindUnused, 8'hFF);
    queue_cmd(crcb_pkg::KindReset, 8'h00);
    queue_cmd(crcb_pkg::KindFinal, 8'h5A);
    queue_cmd(crcb_pkg::KindReset, 8'h80);
    queue_cmd(KindUnused, 8'h00);
    queue_cmd(crcb_pkg::KindData, 8'h80);
    queue_cmd(crcb_pkg::KindData, 8'h01);
    queue_cmd(crcb_pkg::KindFinal, 8'h00);
    queue_cmd(crcb_pkg::KindReset, 8'h00);
    wait_drained();

    // All-zero registers; the remainder carries over until the next reset beat
    apply_settings(32'h0000_0000, 32'h0000_0000);
    queue_random_traffic(45);
    wait_drained();

    // All-ones registers, with one long output hold while input keeps coming
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random_traffic(45);
    @(posedge clk_i);
    hold_request = 1'b1;
    wait_drained();

    apply_settings($urandom(), $urandom());
    queue_random_traffic(45);
    wait_drained();

    // Default registers, no idling on either side
    apply_settings(crcb_pkg::CrcInitRst, crcb_pkg::CrcPolyRst);
    idle_en = 1'b0;
    queue_random_traffic(45);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d data bytes, %0d digests, %0d resets, %0d rejected, %0d unused kinds",
             n_data, n_final, n_reset, n_reject, n_unused);
    $display("Checked %0d result beats over %0d register settings; %0d input stall cycles, %0d long output holds",
             beats_checked, n_settings, in_stall_cycles, n_long_holds);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #(12 * 500000);
    $display("Timeout with %0d result beats still outstanding", crc_beats_due.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
